### hw/rtl/stag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stag_pkg
// Shared constants, register codes and link types of the strided address
// generator.
// ----------------------------------------------------------------------------
package stag_pkg;

    localparam int MAX_RANK   = 8;
    localparam int DIM_WIDTH  = 16;
    localparam int ADDR_WIDTH = 32;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = 16;
    localparam int STRIDE_W   = 16;
    localparam int RANK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OFS_W      = 36;
    localparam int DEST_W     = 32;
    localparam int PROD_W     = DIM_WIDTH + STRIDE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK         = 3'd0,
        REG_BASE_OFFSET  = 3'd1,
        REG_SIZES_LOW    = 3'd2,
        REG_SIZES_HIGH   = 3'd3,
        REG_STRIDES_LOW  = 3'd4,
        REG_STRIDES_HIGH = 3'd5,
        REG_STORAGE_SIZE = 3'd6
    } t_cfg_reg;

    // handed from cell k+1 to cell k
    typedef struct packed {
        logic              carry;
        logic              used;
        logic [PROD_W-1:0] span;
    } t_link;

    // per-word side data that travels with the offset pipeline
    typedef struct packed {
        logic                  last;
        logic                  empty;
        logic [ADDR_WIDTH-1:0] lin;
    } t_side;

endpackage
`default_nettype wire

### hw/rtl/stag_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stag_req_if / stag_rsp_if
// Valid/ready channels of the strided address generator: request words in,
// address words out.
// ----------------------------------------------------------------------------
interface stag_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface stag_rsp_if;
    logic        valid;
    logic        ready;
    logic [35:0] source_offset;
    logic [31:0] dest_index;
    logic        last;
    logic        empty_res;
    logic        contiguous;
    logic        out_of_bounds;

    modport source (output valid, output source_offset, output dest_index, output last,
                    output empty_res, output contiguous, output out_of_bounds,
                    input ready);
    modport sink   (input valid, input source_offset, input dest_index, input last,
                    input empty_res, input contiguous, input out_of_bounds,
                    output ready);
endinterface
`default_nettype wire

### hw/rtl/strided_tensor_address_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// strided_tensor_address_generator
// Row-major walk of a strided view of up to eight dimensions, one element
// address per request word.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries request words (restart bit); o_rsp returns one address word
//   per request: source offset, destination index, last mark and the empty,
//   contiguous and out-of-bounds view flags.
//   The user must write registers through i_cfg_we / i_cfg_index / i_cfg_data
//   only while no word is in flight; the block does not enforce this.
//   Indexes beyond the storage size register are ignored. Throughput is one
//   word per cycle while o_rsp.ready is high. Stride products in the cells are
//   registered at acceptance, then two adder tree levels, then the base add
//   and bounds compare into the output register that drives o_rsp.valid.
//   The index counters advance at acceptance through a carry chain across the
//   eight cells, so consecutive words need no gap.
//   When o_rsp.ready is low the pipeline fills its four stages and i_req.ready
//   drops only when all of them hold words; empty stages are always refilled.
//   Reset clears registers, counters, destination index and all valid bits.
// ----------------------------------------------------------------------------
module strided_tensor_address_generator
    import stag_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    stag_req_if.sink                   i_req,
    stag_rsp_if.source                 o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [RANK_W-1:0]         r_rank;
    logic [ADDR_WIDTH-1:0]     r_base;
    logic [CFG_DATA_W-1:0]     r_sizes_lo;
    logic [CFG_DATA_W-1:0]     r_sizes_hi;
    logic [CFG_DATA_W-1:0]     r_strides_lo;
    logic [CFG_DATA_W-1:0]     r_strides_hi;
    logic [ADDR_WIDTH-1:0]     r_storage;

    logic [2*CFG_DATA_W-1:0]   w_sizes_all;
    logic [2*CFG_DATA_W-1:0]   w_strides_all;
    logic [RANK_W-1:0]         w_used_rank;
    logic [SLOT_COUNT-1:0]     w_used;
    logic [SLOT_COUNT-1:0]     w_zero;
    logic [SLOT_COUNT-1:0]     w_ok;
    logic                      w_empty;
    logic                      w_last;
    t_link                     w_link [SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0][PROD_W-1:0] w_item_prod;
    logic [SLOT_COUNT-1:0][PROD_W-1:0] w_max_prod;
    logic [1:0][OFS_W-1:0]     w_item_quad;
    logic [1:0][OFS_W-1:0]     w_max_quad;
    logic [OFS_W-1:0]          w_ofs;
    logic [OFS_W-1:0]          w_max_ofs;

    logic                      w_en1;
    logic                      w_en2;
    logic                      w_en3;
    logic                      w_en_o;
    logic                      w_accept;

    logic [ADDR_WIDTH-1:0]     r_lin;
    logic [ADDR_WIDTH-1:0]     w_lin_eff;
    logic [ADDR_WIDTH-1:0]     n_lin;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      r_vo;
    t_side                     r_s1;
    t_side                     r_s2;
    t_side                     r_s3;
    logic                      r_contig;

    logic [OFS_W-1:0]          r_o_ofs;
    logic [DEST_W-1:0]         r_o_dest;
    logic                      r_o_last;
    logic                      r_o_empty;
    logic                      r_o_contig;
    logic                      r_o_oob;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank       <= '0;
            r_base       <= '0;
            r_sizes_lo   <= '0;
            r_sizes_hi   <= '0;
            r_strides_lo <= '0;
            r_strides_hi <= '0;
            r_storage    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_RANK:         r_rank       <= i_cfg_data[RANK_W-1:0];
                REG_BASE_OFFSET:  r_base       <= i_cfg_data[ADDR_WIDTH-1:0];
                REG_SIZES_LOW:    r_sizes_lo   <= i_cfg_data;
                REG_SIZES_HIGH:   r_sizes_hi   <= i_cfg_data;
                REG_STRIDES_LOW:  r_strides_lo <= i_cfg_data;
                REG_STRIDES_HIGH: r_strides_hi <= i_cfg_data;
                REG_STORAGE_SIZE: r_storage    <= i_cfg_data[ADDR_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_sizes_all   = {r_sizes_hi, r_sizes_lo};
    assign w_strides_all = {r_strides_hi, r_strides_lo};
    assign w_used_rank   = (r_rank > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : r_rank;

    // pipeline control
    assign w_en_o   = !r_vo || o_rsp.ready;
    assign w_en3    = !r_v3 || w_en_o;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign w_accept = i_req.valid && w_en1;
    assign i_req.ready = w_en1;

    // cell chain, slowest dimension at cell 0
    assign w_link[SLOT_COUNT] = '{carry: 1'b1, used: 1'b0, span: '0};

    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        logic [DIM_WIDTH-1:0] w_size;
        assign w_size    = w_sizes_all[SLOT_W*k +: DIM_WIDTH];
        assign w_used[k] = (RANK_W'(k) < w_used_rank);
        assign w_zero[k] = w_used[k] && (w_size == '0);

        stag_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_size      (w_size),
            .i_stride    (w_strides_all[SLOT_W*k +: STRIDE_W]),
            .i_used      (w_used[k]),
            .i_restart   (i_req.restart),
            .i_accept    (w_accept),
            .i_empty     (w_empty),
            .i_load      (w_en1),
            .i_link      (w_link[k+1]),
            .o_link      (w_link[k]),
            .o_item_prod (w_item_prod[k]),
            .o_max_prod  (w_max_prod[k]),
            .o_ok        (w_ok[k])
        );
    end

    assign w_empty = |w_zero;
    assign w_last  = w_link[0].carry;

    // destination index
    assign w_lin_eff = i_req.restart ? '0 : r_lin;

    always_comb begin
        n_lin = w_lin_eff;
        if (!w_empty) begin
            n_lin = w_last ? '0 : w_lin_eff + ADDR_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin <= '0;
        end else if (w_accept) begin
            r_lin <= n_lin;
        end
    end

    // offset and view-flag adder trees
    stag_sum u_item_sum (
        .i_clk     (i_clk),
        .i_en_pair (w_en2),
        .i_en_quad (w_en3),
        .i_terms   (w_item_prod),
        .o_quad    (w_item_quad)
    );

    stag_sum u_max_sum (
        .i_clk     (i_clk),
        .i_en_pair (1'b1),
        .i_en_quad (1'b1),
        .i_terms   (w_max_prod),
        .o_quad    (w_max_quad)
    );

    always_ff @(posedge i_clk) begin
        r_contig <= (w_used_rank <= RANK_W'(1)) || (&w_ok);
    end

    assign w_ofs     = w_item_quad[0] + w_item_quad[1] + OFS_W'(r_base);
    assign w_max_ofs = w_max_quad[0] + w_max_quad[1] + OFS_W'(r_base);

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en1)  r_v1 <= w_accept;
            if (w_en2)  r_v2 <= r_v1;
            if (w_en3)  r_v3 <= r_v2;
            if (w_en_o) r_vo <= r_v3;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1.last  <= w_last;
            r_s1.empty <= w_empty;
            r_s1.lin   <= w_lin_eff;
        end
        if (w_en2) r_s2 <= r_s1;
        if (w_en3) r_s3 <= r_s2;
        if (w_en_o) begin
            r_o_empty  <= r_s3.empty;
            r_o_ofs    <= r_s3.empty ? '0 : w_ofs;
            r_o_dest   <= r_s3.empty ? '0 : DEST_W'(r_s3.lin);
            r_o_last   <= !r_s3.empty && r_s3.last;
            r_o_contig <= !r_s3.empty && r_contig;
            r_o_oob    <= !r_s3.empty && (w_max_ofs >= OFS_W'(r_storage));
        end
    end

    assign o_rsp.valid         = r_vo;
    assign o_rsp.source_offset = r_o_ofs;
    assign o_rsp.dest_index    = r_o_dest;
    assign o_rsp.last          = r_o_last;
    assign o_rsp.empty_res     = r_o_empty;
    assign o_rsp.contiguous    = r_o_contig;
    assign o_rsp.out_of_bounds = r_o_oob;

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("output valid after reset");

    a_free_pipe_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vo |-> i_req.ready)
        else $error("request stalled with empty output stage");

    a_empty_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.empty_res) |->
        (o_rsp.source_offset == '0 && o_rsp.dest_index == '0 && !o_rsp.last &&
         !o_rsp.contiguous && !o_rsp.out_of_bounds))
        else $error("empty view word carries nonzero fields");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_empty && w_last) |=> (r_lin == '0))
        else $error("destination index not wrapped after last element");

    a_low_rank_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.empty_res && w_used_rank <= RANK_W'(1)) |->
        o_rsp.contiguous)
        else $error("rank one or scalar view not marked contiguous");
`endif

endmodule
`default_nettype wire

### hw/rtl/stag_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stag_cell
// One dimension of the walk: index counter with carry from the faster
// neighbor, stride product of the current word, and the view-flag products.
// ----------------------------------------------------------------------------
module stag_cell
    import stag_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [DIM_WIDTH-1:0] i_size,
    input  wire logic [STRIDE_W-1:0]  i_stride,
    input  wire logic                 i_used,
    input  wire logic                 i_restart,
    input  wire logic                 i_accept,
    input  wire logic                 i_empty,
    input  wire logic                 i_load,
    input  wire t_link                i_link,
    output      t_link                o_link,
    output      logic [PROD_W-1:0]    o_item_prod,
    output      logic [PROD_W-1:0]    o_max_prod,
    output      logic                 o_ok
);

    logic [DIM_WIDTH-1:0] r_cnt;
    logic [DIM_WIDTH-1:0] n_cnt;
    logic [DIM_WIDTH-1:0] w_ceff;
    logic [DIM_WIDTH:0]   w_cinc;
    logic [DIM_WIDTH-1:0] w_size_m1;
    logic [PROD_W-1:0]    w_expect;
    logic                 w_at_end;
    logic [PROD_W-1:0]    r_item;
    logic [PROD_W-1:0]    r_max;
    logic [PROD_W-1:0]    r_span;
    logic                 r_ok;

    assign w_ceff    = i_restart ? '0 : r_cnt;
    assign w_cinc    = {1'b0, w_ceff} + (DIM_WIDTH+1)'(1);
    assign w_at_end  = !(w_cinc < {1'b0, i_size});
    assign w_size_m1 = i_size - DIM_WIDTH'(1);
    assign w_expect  = i_link.used ? i_link.span : PROD_W'(1);

    always_comb begin
        n_cnt = w_ceff;
        if (i_used && !i_empty && i_link.carry) begin
            n_cnt = w_at_end ? '0 : w_cinc[DIM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_used ? PROD_W'(w_ceff) * PROD_W'(i_stride) : '0;
        end
    end

    // view flags follow the registers every cycle
    always_ff @(posedge i_clk) begin
        r_max  <= i_used ? PROD_W'(w_size_m1) * PROD_W'(i_stride) : '0;
        r_span <= PROD_W'(i_stride) * PROD_W'(i_size);
        r_ok   <= !i_used || (PROD_W'(i_stride) == w_expect);
    end

    assign o_link.carry = i_link.carry && (w_at_end || !i_used);
    assign o_link.used  = i_used;
    assign o_link.span  = r_span;
    assign o_item_prod  = r_item;
    assign o_max_prod   = r_max;
    assign o_ok         = r_ok;

endmodule
`default_nettype wire

### hw/rtl/stag_sum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stag_sum
// Two-level registered adder tree: eight products to two partial sums.
// ----------------------------------------------------------------------------
module stag_sum
    import stag_pkg::*;
(
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en_pair,
    input  wire logic                                 i_en_quad,
    input  wire logic [SLOT_COUNT-1:0][PROD_W-1:0]    i_terms,
    output      logic [1:0][OFS_W-1:0]                o_quad
);

    logic [SLOT_COUNT/2-1:0][OFS_W-1:0] r_pair;
    logic [1:0][OFS_W-1:0]              r_quad;

    always_ff @(posedge i_clk) begin
        if (i_en_pair) begin
            for (int j = 0; j < SLOT_COUNT/2; j++) begin
                r_pair[j] <= OFS_W'(i_terms[2*j]) + OFS_W'(i_terms[2*j+1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_quad) begin
            for (int q = 0; q < 2; q++) begin
                r_quad[q] <= r_pair[2*q] + r_pair[2*q+1];
            end
        end
    end

    assign o_quad = r_quad;

endmodule
`default_nettype wire
